FILE: rtl/b64d_pkg.sv
// Shared types, constants and the character classifier of the base64 stream decoder.
package b64d_pkg;

  // Sextet codes beyond the 64 data values
  localparam logic [6:0] SX_PAD = 7'd64;
  localparam logic [6:0] SX_BAD = 7'd65;

  // Depth of the job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One unit of work for the back end: a decoded quartet or an error
  typedef struct packed {
    logic        err;    // error result, carries a position
    logic        last;   // closes the string
    logic [1:0]  nbytes; // data bytes to emit, 1 to 3
    logic [23:0] bytes;  // first byte in the top bits
  } b64d_job_t;

  // Map a character to its sextet; padding and bad characters get their own codes
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] v;
    v = SX_BAD;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      v = 7'(ch - 8'd65);
    end else if (ch >= 8'd97 && ch <= 8'd122) begin
      v = 7'(ch - 8'd71);
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      v = 7'(ch + 8'd4);
    end else if (ch == 8'd43) begin
      v = 7'd62;
    end else if (ch == 8'd47) begin
      v = 7'd63;
    end else if (ch == 8'd61) begin
      v = SX_PAD;
    end
    return v;
  endfunction

endpackage

FILE: rtl/b64d_front.sv
// Front end: classifies characters, gathers quartets and issues decode or error jobs.
module b64d_front
  import b64d_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 char_vld,   // a character transfer at this edge
  input  logic [7:0]           char_code,
  input  logic                 is_last,
  output logic                 job_vld,    // push a job this cycle
  output b64d_job_t            job,
  output logic [POS_WIDTH-1:0] job_pos
);

  logic [1:0]           phase_r, phase_nxt;
  logic [17:0]          buf_r, buf_nxt;
  logic [POS_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                 pad_r, pad_nxt;
  logic                 disc_r, disc_nxt;

  logic [6:0]           sx;
  logic                 is_pad;
  logic [5:0]           sa, sb, sc, sd;
  logic [POS_WIDTH-1:0] qstart;

  assign sx     = sextet_of(char_code);
  assign is_pad = (sx == SX_PAD);
  assign qstart = cnt_r - POS_WIDTH'(phase_r);
  assign sa     = buf_r[17:12];
  assign sb     = buf_r[11:6];
  assign sc     = buf_r[5:0];
  assign sd     = is_pad ? 6'd0 : sx[5:0];

  always_comb begin
    phase_nxt   = phase_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    pad_nxt     = pad_r;
    disc_nxt    = disc_r;
    job_vld     = 1'b0;
    job.err     = 1'b0;
    job.last    = is_last;
    job.nbytes  = 2'd3;
    job.bytes   = {sa, sb[5:4], sb[3:0], sc[5:2], sc[1:0], sd};
    job_pos     = '0;
    if (char_vld) begin
      if (disc_r) begin
        // drop the rest of a failed string
        if (is_last) begin
          disc_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end else if (is_last && phase_r != 2'd3) begin
        job_vld  = 1'b1;
        job.err  = 1'b1;
        job_pos  = cnt_r + POS_WIDTH'(1);
      end else if (sx == SX_BAD || (is_pad && phase_r < 2'd2) || (!is_pad && pad_r) ||
                   (phase_r == 2'd3 && (is_pad || pad_r) && !is_last)) begin
        job_vld  = 1'b1;
        job.err  = 1'b1;
        job_pos  = qstart;
        disc_nxt = !is_last;
      end else if (phase_r != 2'd3) begin
        buf_nxt   = {buf_r[11:0], sd};
        pad_nxt   = pad_r | is_pad;
        phase_nxt = phase_r + 2'd1;
        cnt_nxt   = cnt_r + POS_WIDTH'(1);
      end else begin
        job_vld    = 1'b1;
        job.nbytes = pad_r ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
        cnt_nxt    = is_last ? '0 : cnt_r + POS_WIDTH'(1);
      end
      // any job ends the quartet
      if (job_vld) begin
        phase_nxt = 2'd0;
        buf_nxt   = '0;
        pad_nxt   = 1'b0;
        if (is_last) begin
          cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      buf_r   <= '0;
      cnt_r   <= '0;
      pad_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      pad_r   <= pad_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
// Job queue between front and back end: small register FIFO with fall-through read.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvld,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, rptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign rvld    = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("job queue count beyond depth");

  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> $stable(cnt_r))
    else $error("job queue count moved while full");

endmodule

FILE: rtl/b64d_back.sv
// Back end: unrolls one job into result transfers, holding the current result in a register.
module b64d_back
  import b64d_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_vld,
  input  b64d_job_t            job,
  input  logic [POS_WIDTH-1:0] job_pos,
  output logic                 job_pop,
  output logic                 res_vld,
  input  logic                 res_rdy,
  output logic [7:0]           res_byte,
  output logic                 res_err,
  output logic [POS_WIDTH-1:0] res_pos,
  output logic                 res_last
);

  b64d_job_t            cur_r;
  logic [POS_WIDTH-1:0] pos_r;
  logic                 vld_r;
  logic [1:0]           idx_r;
  logic                 final_beat, load;

  assign final_beat = cur_r.err || (idx_r == cur_r.nbytes - 2'd1);
  assign load       = !vld_r || (res_rdy && final_beat);
  assign job_pop    = load && job_vld;

  assign res_vld  = vld_r;
  assign res_err  = cur_r.err;
  assign res_pos  = cur_r.err ? pos_r : '0;
  assign res_last = cur_r.err || (cur_r.last && final_beat);

  always_comb begin
    res_byte = 8'd0;
    if (!cur_r.err) begin
      case (idx_r)
        2'd0:    res_byte = cur_r.bytes[23:16];
        2'd1:    res_byte = cur_r.bytes[15:8];
        default: res_byte = cur_r.bytes[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job;
      pos_r <= job_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= job_vld;
      idx_r <= '0;
    end else if (res_rdy) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !cur_r.err |-> idx_r < cur_r.nbytes)
    else $error("result index past byte count");

endmodule

FILE: rtl/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: front end, job queue and back end.
// Path: the front end classifies combinationally and writes the job that completes a quartet
//   into the job queue; the back end loads it from there into its output register when free.
// Throughput: one character per cycle while the queue has room; the back end emits one
//   result per cycle while out_tready is high, and a quartet yields up to three bytes.
// Reset: synchronous, active low; clears quartet state, queue and output register.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input: base64 text, one character per transfer
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] char_code
  input  logic                                  in_tlast,  // is_last
  // output: decoded bytes or a single error result
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((8+POS_WIDTH+7)/8)*8-1:0]      out_tdata, // [7:0] data_byte, then error_pos
  output logic                                  out_tuser, // is_error
  output logic                                  out_tlast  // last_of_run
);

  localparam int unsigned TDATA_W = ((8 + POS_WIDTH + 7) / 8) * 8;
  localparam int unsigned QW      = $bits(b64d_job_t) + POS_WIDTH;

  logic                 char_vld;
  logic                 fe_vld;
  b64d_job_t            fe_job;
  logic [POS_WIDTH-1:0] fe_pos;
  logic                 q_full, q_vld, q_pop;
  logic [QW-1:0]        q_rdata;
  b64d_job_t            be_job;
  logic [POS_WIDTH-1:0] be_pos;
  logic [7:0]           res_byte;
  logic [POS_WIDTH-1:0] res_pos;

  // Take a character whenever the queue has room for the job it might cause
  assign in_tready = !q_full;
  assign char_vld  = in_tvalid && in_tready;

  b64d_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_vld  (char_vld),
    .char_code (in_tdata),
    .is_last   (in_tlast),
    .job_vld   (fe_vld),
    .job       (fe_job),
    .job_pos   (fe_pos)
  );

  // Queue parts the front end from output backpressure
  b64d_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_vld),
    .wdata ({fe_pos, fe_job}),
    .full  (q_full),
    .pop   (q_pop),
    .rvld  (q_vld),
    .rdata (q_rdata)
  );

  assign be_job = q_rdata[$bits(b64d_job_t)-1:0];
  assign be_pos = q_rdata[QW-1:$bits(b64d_job_t)];

  b64d_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_vld  (q_vld),
    .job      (be_job),
    .job_pos  (be_pos),
    .job_pop  (q_pop),
    .res_vld  (out_tvalid),
    .res_rdy  (out_tready),
    .res_byte (res_byte),
    .res_err  (out_tuser),
    .res_pos  (res_pos),
    .res_last (out_tlast)
  );

  // Pack error_pos above data_byte, zero fill to whole bytes
  assign out_tdata = TDATA_W'({res_pos, res_byte});

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("error result must close the string with a zero byte");

endmodule
